// ===== sv/rxs_pkg.sv =====
// Shared types, constants and key selection for the record exchange sort core.
package rxs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_W       = 16;
  localparam int TDATA_W     = 72;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b1;

  typedef enum logic [1:0] {
    KEY_PH   = 2'd0,
    KEY_COND = 2'd1,
    KEY_TURB = 2'd2,
    KEY_COLI = 2'd3
  } key_sel_t;

  // Packed with tag in the lowest bits, matching the beat layout
  typedef struct packed {
    logic [15:0] coliforms;
    logic [15:0] turbidity;
    logic [15:0] conductivity;
    logic [10:0] ph_centi;
    logic [7:0]  tag;
  } record_t;

  localparam int REC_W = $bits(record_t);

  function automatic logic [KEY_W-1:0] key_of(input record_t r, input key_sel_t sel);
    logic [KEY_W-1:0] k;
    case (sel)
      KEY_PH:   k = {5'b0, r.ph_centi};
      KEY_COND: k = r.conductivity;
      KEY_TURB: k = r.turbidity;
      KEY_COLI: k = r.coliforms;
      default:  k = r.coliforms;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/rxs_store.sv =====
// Record store: one write port, one read port with registered read data.
module rxs_store #(
  parameter int DEPTH = rxs_pkg::MAX_RECORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rxs_pkg::record_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rxs_pkg::record_t         rdata
);

  rxs_pkg::record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rxs_cmp.sv =====
// Shared compare unit: picks the sort key of two records and decides a swap.
module rxs_cmp (
  input  rxs_pkg::record_t  rec_a,
  input  rxs_pkg::record_t  rec_b,
  input  rxs_pkg::key_sel_t sort_key,
  input  logic              descending,
  output logic              swap
);

  logic [rxs_pkg::KEY_W-1:0] key_a;
  logic [rxs_pkg::KEY_W-1:0] key_b;

  assign key_a = rxs_pkg::key_of(rec_a, sort_key);
  assign key_b = rxs_pkg::key_of(rec_b, sort_key);
  assign swap  = descending ? (key_a < key_b) : (key_a > key_b);

endmodule

// ===== sv/record_exchange_sort_core.sv =====
// Top level of the record exchange sort core: loader, sort sequencer and emitter.
//
// Records are loaded one beat per cycle into a store of MAX_RECORDS entries; beats
// that arrive with the store full are dropped and flag the whole set (tuser).
// The beat with tlast starts an exchange sort of the n held records: one compare
// and conditional swap per cycle through a single comparator against record i held
// in a register; each outer pass stores row i and fetches row i+1. The store
// has one read port, which sets the one-compare-per-cycle figure. The sorted records
// then leave one beat at a time while the sink is ready, each read from the store
// after the previous beat is taken. No input is taken from the tlast beat until
// the last sorted beat has been handed over.
module record_exchange_sort_core #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rxs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rxs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tag[7:0], ph_centi[18:8], conductivity[34:19], turbidity[50:35],
  // coliforms[66:51], zeros above
  input  logic [rxs_pkg::TDATA_W-1:0]    s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_tag[7:0], out_ph_centi[18:8], out_conductivity[34:19],
  // out_turbidity[50:35], out_coliforms[66:51], zeros above
  output logic [rxs_pkg::TDATA_W-1:0]    m_tdata,
  output logic                           m_tlast,
  // overflow[0]
  output logic                           m_tuser
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FETCH_I = 7'b0000010,
    S_LOAD_I  = 7'b0000100,
    S_CMP     = 7'b0001000,
    S_STORE_I = 7'b0010000,
    S_E_RD    = 7'b0100000,
    S_E_WAIT  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              dropped, dropped_next;
  logic [AW-1:0]     i, i_next;
  logic [AW-1:0]     j, j_next;
  logic [AW-1:0]     k, k_next;
  rxs_pkg::record_t  rec_i, rec_i_next;
  rxs_pkg::key_sel_t sort_key;
  logic              descending;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  rxs_pkg::record_t  wdata, rdata;
  logic              swap;
  logic [CW-1:0]     count_m1, count_m2;
  logic              in_beat, full;

  rxs_store #(.DEPTH(MAX_RECORDS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rxs_cmp u_cmp (
    .rec_a      (rec_i),
    .rec_b      (rdata),
    .sort_key   (sort_key),
    .descending (descending),
    .swap       (swap)
  );

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign full     = (count == CW'(MAX_RECORDS));
  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);

  assign m_tvalid = (state == S_E_WAIT);
  assign m_tdata  = {{(rxs_pkg::TDATA_W - rxs_pkg::REC_W){1'b0}}, rdata};
  assign m_tlast  = (CW'(k) == count_m1);
  assign m_tuser  = dropped;

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    rec_i_next   = rec_i;
    we           = 1'b0;
    waddr        = i;
    wdata        = rec_i;
    re           = 1'b0;
    raddr        = i;
    case (state)
      S_IDLE: begin
        waddr = count[AW-1:0];
        wdata = rxs_pkg::record_t'(s_tdata[rxs_pkg::REC_W-1:0]);
        if (in_beat) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            we         = 1'b1;
            count_next = count + CW'(1);
          end
          if (s_tlast) begin
            i_next = '0;
            k_next = '0;
            state_next = (count_next < CW'(2)) ? S_E_RD : S_FETCH_I;
          end
        end
      end
      S_FETCH_I: begin
        re         = 1'b1;
        raddr      = i;
        j_next     = i + AW'(1);
        state_next = S_LOAD_I;
      end
      S_LOAD_I: begin
        rec_i_next = rdata;
        re         = 1'b1;
        raddr      = j;
        state_next = S_CMP;
      end
      S_CMP: begin
        // record i lives in rec_i until its row is finished
        waddr = j;
        wdata = rec_i;
        if (swap) begin
          we         = 1'b1;
          rec_i_next = rdata;
        end
        if (CW'(j) == count_m1) begin
          state_next = S_STORE_I;
        end else begin
          j_next = j + AW'(1);
          re     = 1'b1;
          raddr  = j + AW'(1);
        end
      end
      S_STORE_I: begin
        we    = 1'b1;
        waddr = i;
        wdata = rec_i;
        if (CW'(i) == count_m2) begin
          k_next     = '0;
          state_next = S_E_RD;
        end else begin
          i_next     = i + AW'(1);
          j_next     = i + AW'(2);
          re         = 1'b1;
          raddr      = i + AW'(1);
          state_next = S_LOAD_I;
        end
      end
      S_E_RD: begin
        re         = 1'b1;
        raddr      = k;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (m_tready) begin
          if (m_tlast) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = S_IDLE;
          end else begin
            k_next     = k + AW'(1);
            state_next = S_E_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    i     <= i_next;
    j     <= j_next;
    k     <= k_next;
    rec_i <= rec_i_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key   <= rxs_pkg::KEY_PH;
      descending <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rxs_pkg::REG_SORT_KEY:   sort_key   <= rxs_pkg::key_sel_t'(cfg_data[1:0]);
        rxs_pkg::REG_DESCENDING: descending <= cfg_data[0];
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECORDS))
    else $error("record count beyond store depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("loading while emitting");

  a_inner_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (j > i) && (CW'(j) <= count_m1))
    else $error("inner index out of range");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (count == '0) && !dropped && s_tready)
    else $error("set not cleared after final beat");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_RD) |-> (count != '0))
    else $error("emitting an empty set");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for record_exchange_sort_core: record sets, sort predictor, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW             = rxs_pkg::TDATA_W;
  localparam int ITEM_BUDGET    = 360;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  typedef struct {
    rxs_pkg::record_t rec;
    bit               last;
    bit               ovf;
  } sorted_beat_t;

  // Holds the set being loaded, sorts it on the closing beat and queues the sorted beats
  class record_scoreboard;
    rxs_pkg::record_t  held[rxs_pkg::MAX_RECORDS];
    int                held_count;
    bit                dropped;
    rxs_pkg::key_sel_t key_sel;
    bit                desc;
    sorted_beat_t      sorted_q[$];
    int                errors;

    function new();
      held_count = 0;
      dropped    = 0;
      key_sel    = rxs_pkg::KEY_PH;
      desc       = 0;
      errors     = 0;
    endfunction

    function void set_key(rxs_pkg::key_sel_t k);
      key_sel = k;
    endfunction

    function void set_order(bit d);
      desc = d;
    endfunction

    function logic [15:0] sort_value(rxs_pkg::record_t r);
      case (key_sel)
        rxs_pkg::KEY_PH:   return {5'b0, r.ph_centi};
        rxs_pkg::KEY_COND: return r.conductivity;
        rxs_pkg::KEY_TURB: return r.turbidity;
        default:           return r.coliforms;
      endcase
    endfunction

    function void note_record(rxs_pkg::record_t r, bit last);
      rxs_pkg::record_t tmp;
      sorted_beat_t     b;
      if (held_count < rxs_pkg::MAX_RECORDS) begin
        held[held_count] = r;
        held_count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      for (int i = 0; i + 1 < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          if (desc ? (sort_value(held[i]) < sort_value(held[j]))
                   : (sort_value(held[i]) > sort_value(held[j]))) begin
            tmp     = held[i];
            held[i] = held[j];
            held[j] = tmp;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        b.rec  = held[k];
        b.last = (k == held_count - 1);
        b.ovf  = dropped;
        sorted_q.push_back(b);
      end
      held_count = 0;
      dropped    = 0;
    endfunction

    function void check_beat(rxs_pkg::record_t r, bit last, bit ovf);
      sorted_beat_t b;
      if (sorted_q.size() == 0) begin
        $error("unexpected output beat: tag %0d", r.tag);
        errors++;
        return;
      end
      b = sorted_q.pop_front();
      if (r.tag !== b.rec.tag) begin
        $error("out_tag expected %0d got %0d", b.rec.tag, r.tag);
        errors++;
      end
      if (r.ph_centi !== b.rec.ph_centi) begin
        $error("out_ph_centi expected %0d got %0d", b.rec.ph_centi, r.ph_centi);
        errors++;
      end
      if (r.conductivity !== b.rec.conductivity) begin
        $error("out_conductivity expected %0d got %0d", b.rec.conductivity, r.conductivity);
        errors++;
      end
      if (r.turbidity !== b.rec.turbidity) begin
        $error("out_turbidity expected %0d got %0d", b.rec.turbidity, r.turbidity);
        errors++;
      end
      if (r.coliforms !== b.rec.coliforms) begin
        $error("out_coliforms expected %0d got %0d", b.rec.coliforms, r.coliforms);
        errors++;
      end
      if (last !== b.last) begin
        $error("out_last expected %0d got %0d", b.last, last);
        errors++;
      end
      if (ovf !== b.ovf) begin
        $error("overflow expected %0d got %0d", b.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [rxs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rxs_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [DW-1:0]                  s_tdata;
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [DW-1:0]                  m_tdata;
  logic                           m_tlast;
  logic                           m_tuser;

  record_scoreboard sb = new();
  int               items_sent;
  int               burst_left;

  record_exchange_sort_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rxs_pkg::record_t make_rec(logic [7:0] tag, logic [10:0] ph,
                                                logic [15:0] cond, logic [15:0] turb,
                                                logic [15:0] coli);
    rxs_pkg::record_t r;
    r.tag          = tag;
    r.ph_centi     = ph;
    r.conductivity = cond;
    r.turbidity    = turb;
    r.coliforms    = coli;
    return r;
  endfunction

  // narrow: measurements squeezed into 0..3 so that equal keys are common
  function automatic rxs_pkg::record_t rand_rec(bit narrow);
    rxs_pkg::record_t r;
    r.tag = 8'($urandom_range(0, 255));
    if (narrow) begin
      r.ph_centi     = 11'($urandom_range(0, 3));
      r.conductivity = 16'($urandom_range(0, 3));
      r.turbidity    = 16'($urandom_range(0, 3));
      r.coliforms    = 16'($urandom_range(0, 3));
    end else begin
      r.ph_centi     = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(1401, 2047))
                                                    : 11'($urandom_range(0, 1400));
      r.conductivity = 16'($urandom_range(0, 65535));
      r.turbidity    = 16'($urandom_range(0, 65535));
      r.coliforms    = 16'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  task automatic send_beat(rxs_pkg::record_t r, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(DW - rxs_pkg::REC_W){1'b0}}, r};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_record(r, last);
    items_sent++;
    burst_left--;
  endtask

  // Lower valid and let the core drain completely
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rxs_pkg::CFG_IDX_W-1:0] idx,
                           logic [rxs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == rxs_pkg::REG_SORT_KEY) sb.set_key(rxs_pkg::key_sel_t'(val));
    else sb.set_order(val[0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_set(int n, bit narrow);
    for (int k = 0; k < n; k++) send_beat(rand_rec(narrow), k == n - 1);
  endtask

  // Sink: ready pattern switches between modes of random length
  initial begin : sink_ready
    ready_mode_t mode;
    int          len;
    int          phase;
    m_tready = 1'b0;
    phase    = 0;
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(10, 150);
      repeat (len) begin
        @(negedge clk);
        phase++;
        case (mode)
          RDY_ALWAYS:   m_tready <= 1'b1;
          RDY_COIN:     m_tready <= 1'($urandom_range(0, 1));
          RDY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
          default:      m_tready <= ((phase % 8) < 5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_beat(m_tdata[rxs_pkg::REC_W-1:0], m_tlast, m_tuser);
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int set_no;
    int n;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-record sets at the field extremes; pH above 1400 rides along
    send_beat(make_rec(8'hFF, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1);
    send_beat(make_rec(8'h00, 11'd0, 16'd0, 16'd0, 16'd0), 1);
    // Reset setting: pH, smallest first, with a tie
    send_beat(make_rec(8'd1, 11'd1400, 16'd7, 16'd7, 16'd7), 0);
    send_beat(make_rec(8'd2, 11'd0, 16'd6, 16'd6, 16'd6), 0);
    send_beat(make_rec(8'd3, 11'd700, 16'd5, 16'd5, 16'd5), 0);
    send_beat(make_rec(8'd4, 11'd700, 16'd4, 16'd4, 16'd4), 0);
    send_beat(make_rec(8'd5, 11'd1401, 16'd3, 16'd3, 16'd3), 1);
    wait_idle();
    write_reg(rxs_pkg::REG_SORT_KEY, rxs_pkg::CFG_DATA_W'(rxs_pkg::KEY_COND));
    write_reg(rxs_pkg::REG_DESCENDING, 2'd1);
    send_beat(make_rec(8'd10, 11'd1, 16'd5, 16'd0, 16'd0), 0);
    send_beat(make_rec(8'd11, 11'd2, 16'd9, 16'd0, 16'd0), 0);
    send_beat(make_rec(8'd12, 11'd3, 16'd5, 16'd0, 16'd0), 0);
    send_beat(make_rec(8'd13, 11'd4, 16'd0, 16'd0, 16'd0), 0);
    send_beat(make_rec(8'd14, 11'd5, 16'hFFFF, 16'd0, 16'd0), 1);
    wait_idle();
    write_reg(rxs_pkg::REG_SORT_KEY, rxs_pkg::CFG_DATA_W'(rxs_pkg::KEY_TURB));
    write_reg(rxs_pkg::REG_DESCENDING, 2'd0);
    send_beat(make_rec(8'd20, 11'd9, 16'd1, 16'd3, 16'd1), 0);
    send_beat(make_rec(8'd21, 11'd8, 16'd2, 16'd3, 16'd2), 0);
    send_beat(make_rec(8'd22, 11'd7, 16'd3, 16'd1, 16'd3), 1);
    wait_idle();
    write_reg(rxs_pkg::REG_SORT_KEY, rxs_pkg::CFG_DATA_W'(rxs_pkg::KEY_COLI));
    write_reg(rxs_pkg::REG_DESCENDING, 2'd1);
    send_beat(make_rec(8'd30, 11'd1, 16'd1, 16'd1, 16'd0), 0);
    send_beat(make_rec(8'd31, 11'd2, 16'd2, 16'd2, 16'hFFFF), 0);
    send_beat(make_rec(8'd32, 11'd3, 16'd3, 16'd3, 16'd0), 1);

    set_no = 0;
    while (items_sent < ITEM_BUDGET) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        if ($urandom_range(0, 2) != 0)
          write_reg(rxs_pkg::REG_SORT_KEY, rxs_pkg::CFG_DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 2) != 0)
          write_reg(rxs_pkg::REG_DESCENDING, rxs_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      end
      // Early sets: overflow with the closing beat dropped, then an exactly full store
      if (set_no == 0) n = rxs_pkg::MAX_RECORDS + 2;
      else if (set_no == 1) n = rxs_pkg::MAX_RECORDS;
      else if ($urandom_range(0, 11) == 0)
        n = $urandom_range(rxs_pkg::MAX_RECORDS - 1, rxs_pkg::MAX_RECORDS + 6);
      else n = $urandom_range(1, 10);
      send_set(n, $urandom_range(0, 2) == 0);
      set_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rxs_pkg.sv
sv/rxs_store.sv
sv/rxs_cmp.sv
sv/record_exchange_sort_core.sv
tb/sv/testbench.sv
